>>> rtl/mtde_pkg.sv
// shared types and constants of the midi track delta time encoder
package mtde_pkg;

	// operation carried in the input item's tuser
	typedef enum logic [1:0] {
		OP_TIME    = 2'd0,
		OP_PAYLOAD = 2'd1,
		OP_END     = 2'd2
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIFF,
		ST_ABS,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_SUM,
		ST_CHECK,
		ST_ROUND,
		ST_PACK,
		ST_EMIT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic diff;
		logic absv;
		logic mul_lo;
		logic mul_hi;
		logic sum;
		logic check;
		logic round;
		logic pack;
		logic emit;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;
		logic last_byte;
	} dp_sts_t;

	localparam logic [31:0] TPS_RESET  = 32'd24931477;
	localparam logic [27:0] VLQ_MAX    = 28'hFFFFFFF;
	localparam logic [80:0] PROD_LIMIT = 81'd1 << 53;
	localparam logic [55:0] Q_HALF     = 56'h800000;
	localparam logic [24:0] ERR_HALF   = 25'h800000;
	localparam logic [7:0]  VLQ_CONT   = 8'h80;
	localparam logic [7:0]  META_MARK  = 8'hFF;
	localparam logic [7:0]  META_EOT   = 8'h2F;

endpackage

>>> rtl/mtde_ctrl.sv
// controller state machine of the delta time encoder
module mtde_ctrl import mtde_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] in_op,
	output logic       in_ready,
	output dp_cmd_t    cmd,
	input  dp_sts_t    sts
);

	state_t state_q, state_nxt;
	logic   accept;

	assign accept = in_valid && (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (in_op)
						OP_TIME:                 state_nxt = ST_DIFF;
						OP_PAYLOAD, OP_END:      state_nxt = ST_EMIT;
						default:                 state_nxt = ST_IDLE;
					endcase
				end
			end
			ST_DIFF:   state_nxt = ST_ABS;
			ST_ABS:    state_nxt = ST_MUL_LO;
			ST_MUL_LO: state_nxt = ST_MUL_HI;
			ST_MUL_HI: state_nxt = ST_SUM;
			ST_SUM:    state_nxt = ST_CHECK;
			ST_CHECK:  state_nxt = ST_ROUND;
			ST_ROUND:  state_nxt = ST_PACK;
			ST_PACK:   state_nxt = ST_EMIT;
			ST_EMIT: begin
				if (sts.out_free && sts.last_byte) begin
					state_nxt = ST_IDLE;
				end
			end
			default:   state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready    = (state_q == ST_IDLE);
		cmd         = '0;
		cmd.capture = accept;
		unique case (state_q)
			ST_DIFF:   cmd.diff   = 1'b1;
			ST_ABS:    cmd.absv   = 1'b1;
			ST_MUL_LO: cmd.mul_lo = 1'b1;
			ST_MUL_HI: cmd.mul_hi = 1'b1;
			ST_SUM:    cmd.sum    = 1'b1;
			ST_CHECK:  cmd.check  = 1'b1;
			ST_ROUND:  cmd.round  = 1'b1;
			ST_PACK:   cmd.pack   = 1'b1;
			ST_EMIT:   cmd.emit   = sts.out_free;
			default:   cmd.emit   = 1'b0;
		endcase
	end

endmodule

>>> rtl/mtde_dp.sv
// datapath: tick arithmetic, vlq packing and output register
module mtde_dp import mtde_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,
	input  logic [55:0] in_data,
	input  logic [1:0]  in_op,
	input  dp_cmd_t     cmd,
	output dp_sts_t     sts,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [39:0] out_data,
	output logic        out_last
);

	logic [31:0]      tps_q;
	logic [47:0]      last_frame_q;
	logic [24:0]      err_q;
	logic [31:0]      count_q;

	logic [47:0]      frame_q;
	logic [48:0]      diff_q;
	logic             neg_q;
	logic [47:0]      mag_q;
	logic [55:0]      pp_lo_q, pp_hi_q;
	logic [79:0]      prod_q;
	logic             sat_q;
	logic [55:0]      t_q;
	logic [27:0]      v_q;
	logic [3:0][7:0]  bytes_q;
	logic [1:0]       last_idx_q, idx_q;

	logic             out_valid_q, out_last_q;
	logic [7:0]       out_byte_q;
	logic [31:0]      out_len_q;

	logic [23:0]      mul_a;
	logic [55:0]      mul_p;
	logic [80:0]      lim_sum;
	logic [55:0]      p_ext, p_sgn, t_nxt, u;
	logic [27:0]      v_nxt;
	logic [24:0]      err_nxt;

	// one 24x32 multiplier shared over the two halves of the magnitude
	assign mul_a = cmd.mul_hi ? mag_q[47:24] : mag_q[23:0];
	assign mul_p = {32'd0, mul_a} * {24'd0, tps_q};

	// saturation test: (mag + 1) * tps above 2^53
	assign lim_sum = {1'b0, prod_q} + {49'd0, tps_q};
	assign p_ext   = {1'b0, prod_q[54:0]};
	assign p_sgn   = neg_q ? (56'd0 - p_ext) : p_ext;
	assign t_nxt   = p_sgn + {{31{err_q[24]}}, err_q};

	// round half up
	assign u = t_q + Q_HALF;

	always_comb begin
		if (sat_q) begin
			v_nxt   = neg_q ? 28'd0 : VLQ_MAX;
			err_nxt = 25'd0;
		end else begin
			err_nxt = {1'b0, u[23:0]} - ERR_HALF;
			if (u[55]) begin
				v_nxt = 28'd0;
			end else if (|u[54:52]) begin
				v_nxt = VLQ_MAX;
			end else begin
				v_nxt = u[51:24];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q        <= TPS_RESET;
			last_frame_q <= '0;
			err_q        <= '0;
			count_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				tps_q <= cfg_wr_data;
			end
			if (cmd.diff) begin
				last_frame_q <= frame_q;
			end
			if (cmd.round) begin
				err_q <= err_nxt;
			end
			if (cmd.emit) begin
				count_q     <= count_q + 32'd1;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			frame_q <= in_data[47:0];
			idx_q   <= 2'd0;
			case (in_op)
				OP_PAYLOAD: begin
					bytes_q[0] <= in_data[55:48];
					last_idx_q <= 2'd0;
				end
				OP_END: begin
					bytes_q    <= {8'h00, META_EOT, META_MARK, 8'h00};
					last_idx_q <= 2'd3;
				end
				default: begin
					last_idx_q <= 2'd0;
				end
			endcase
		end
		if (cmd.diff) begin
			diff_q <= {1'b0, frame_q} - {1'b0, last_frame_q};
		end
		if (cmd.absv) begin
			neg_q <= diff_q[48];
			mag_q <= diff_q[48] ? 48'(49'd0 - diff_q) : diff_q[47:0];
		end
		if (cmd.mul_lo) begin
			pp_lo_q <= mul_p;
		end
		if (cmd.mul_hi) begin
			pp_hi_q <= mul_p;
		end
		if (cmd.sum) begin
			prod_q <= {24'd0, pp_lo_q} + {pp_hi_q, 24'd0};
		end
		if (cmd.check) begin
			sat_q <= (lim_sum > PROD_LIMIT);
			t_q   <= t_nxt;
		end
		if (cmd.round) begin
			v_q <= v_nxt;
		end
		if (cmd.pack) begin
			idx_q <= 2'd0;
			if (|v_q[27:21]) begin
				bytes_q    <= {1'b0, v_q[6:0], VLQ_CONT | {1'b0, v_q[13:7]},
				               VLQ_CONT | {1'b0, v_q[20:14]}, VLQ_CONT | {1'b0, v_q[27:21]}};
				last_idx_q <= 2'd3;
			end else if (|v_q[20:14]) begin
				bytes_q    <= {8'h00, 1'b0, v_q[6:0], VLQ_CONT | {1'b0, v_q[13:7]},
				               VLQ_CONT | {1'b0, v_q[20:14]}};
				last_idx_q <= 2'd2;
			end else if (|v_q[13:7]) begin
				bytes_q    <= {16'h0000, 1'b0, v_q[6:0], VLQ_CONT | {1'b0, v_q[13:7]}};
				last_idx_q <= 2'd1;
			end else begin
				bytes_q    <= {24'h000000, 1'b0, v_q[6:0]};
				last_idx_q <= 2'd0;
			end
		end
		if (cmd.emit) begin
			out_byte_q <= bytes_q[idx_q];
			out_last_q <= (idx_q == last_idx_q);
			out_len_q  <= count_q + 32'd1;
			idx_q      <= idx_q + 2'd1;
		end
	end

	assign sts.out_free  = !out_valid_q || out_ready;
	assign sts.last_byte = (idx_q == last_idx_q);

	assign out_valid = out_valid_q;
	assign out_data  = {out_len_q, out_byte_q};
	assign out_last  = out_last_q;

endmodule

>>> rtl/midi_track_delta_time_encoder_top.sv
// top level of the midi track delta time encoder
//
// builds the byte stream of a midi track body, one item at a time. a
// timestamp item turns the frame distance since the previous timestamp into
// ticks with the unsigned q8.24 tick scale factor, adds the carried rounding
// residual, rounds half up and sends the delta as a 1 to 4 byte
// variable-length quantity (clamped to 0..0x0fffffff, a negative distance
// gives 0, (dist + 1) * scale above 2^53 saturates and clears the residual).
// a payload item passes its byte through, an end item sends 00 ff 2f 00 and
// operation code 3 is taken and dropped. every byte carries the running
// 32-bit track length. one item is worked on at a time: a timestamp goes
// through difference, magnitude, two passes of a shared 24x32 multiplier,
// sum, saturation check, rounding and packing, then sends one byte a cycle
// while m_tready allows; a payload or end item goes straight to sending.
// the next item is taken while the final byte of the previous one still
// waits in the output register. the user must write the tick scale through
// cfg_wr_en/cfg_wr_data only while idle; the block does not enforce this.
module midi_track_delta_time_encoder_top import mtde_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: tick scale factor, unsigned q8.24
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,
	// input items
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // frame_time[47:0], payload_byte[55:48]
	input  logic [1:0]  s_tuser,   // operation[1:0]
	// output items
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // out_byte[7:0], track_length[39:8]
	output logic        m_tlast    // last_of_run
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	// sequencing of one item
	mtde_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_op    (s_tuser),
		.in_ready (s_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	// arithmetic, byte packing, length counter and output register
	mtde_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_data     (s_tdata),
		.in_op       (s_tuser),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_data    (m_tdata),
		.out_last    (m_tlast)
	);

endmodule

>>> sim/testbench.sv
// self-checking testbench of the midi track delta time encoder
`timescale 1ns / 1ps

module testbench import mtde_pkg::*;;

	localparam logic [1:0]  OP_UNUSED   = 2'd3;
	localparam longint      DELTA_CAP   = 64'h0FFF_FFFF;
	localparam logic [31:0] TPS_ONE     = 32'h0100_0000;
	localparam logic [31:0] TPS_HALF    = 32'h0080_0000;
	localparam int          SETTLE_CYC  = 24;

	typedef struct packed {
		logic [7:0]  body_byte;
		logic        run_end;
		logic [31:0] length;
	} track_byte_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [31:0] cfg_wr_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata = '0;   // frame_time[47:0], payload_byte[55:48]
	logic [1:0]  s_tuser = '0;   // operation[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;        // out_byte[7:0], track_length[39:8]
	logic        m_tlast;

	// predictor state
	logic [31:0] tps_q = TPS_RESET;
	logic [47:0] prev_frame = '0;
	logic [24:0] residual = '0;
	logic [31:0] length_count = '0;

	track_byte_t pending_bytes[$];
	track_byte_t next_byte;
	int          mismatch_count = 0;
	int          rx_gap = 0;
	bit          rx_idle_en = 1'b0;
	bit          tx_idle_en = 1'b0;

	midi_track_delta_time_encoder_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

	always #2 clk = ~clk;

	initial begin
		#4_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// ---------------------------------------------------------------- predictor

	function automatic logic [27:0] ticks_since_last(input logic [47:0] frame);
		longint          frame_gap;
		longint unsigned mag;
		longint          scaled;
		longint          rnd;
		longint          rest;
		logic [27:0]     delta;
		frame_gap = longint'({16'd0, frame}) - longint'({16'd0, prev_frame});
		mag = (frame_gap < 0) ? -frame_gap : frame_gap;
		prev_frame = frame;
		if (tps_q != 0 && mag >= ((64'd1 << 53) / {32'd0, tps_q})) begin
			// product out of range: saturate and drop the residual
			residual = '0;
			delta = (frame_gap < 0) ? 28'd0 : DELTA_CAP[27:0];
		end else begin
			scaled = frame_gap * longint'({32'd0, tps_q}) + longint'($signed(residual));
			rnd = (scaled + 64'sd8388608) >>> 24;
			rest = scaled - (rnd <<< 24);
			residual = rest[24:0];
			if (rnd < 0)
				delta = 28'd0;
			else if (rnd > DELTA_CAP)
				delta = DELTA_CAP[27:0];
			else
				delta = rnd[27:0];
		end
		return delta;
	endfunction

	task automatic append_byte(input logic [7:0] b, input logic run_end);
		length_count = length_count + 32'd1;
		pending_bytes.push_back('{body_byte: b, run_end: run_end, length: length_count});
	endtask

	task automatic predict_track_bytes(input logic [1:0] op, input logic [47:0] frame,
			input logic [7:0] payload);
		logic [27:0] delta;
		int          nbytes;
		case (op)
			OP_TIME: begin
				delta = ticks_since_last(frame);
				nbytes = (delta >= 28'h20_0000) ? 4 : (delta >= 28'h4000) ? 3 :
					(delta >= 28'h80) ? 2 : 1;
				// most significant group first, continuation bit on all but the last
				for (int k = nbytes - 1; k >= 0; k--)
					append_byte((k != 0 ? VLQ_CONT : 8'h00) | 8'(7'(delta >> (7 * k))),
						k == 0);
			end
			OP_PAYLOAD: append_byte(payload, 1'b1);
			OP_END: begin
				append_byte(8'h00, 1'b0);
				append_byte(META_MARK, 1'b0);
				append_byte(META_EOT, 1'b0);
				append_byte(8'h00, 1'b1);
			end
			default: ;
		endcase
	endtask

	// ---------------------------------------------------------------- checking

	always @(posedge clk) begin
		if (m_tvalid === 1'b1 && m_tready) begin
			if (pending_bytes.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected item: byte %02h last %0b length %0d",
						m_tdata[7:0], m_tlast, m_tdata[39:8]);
			end else begin
				next_byte = pending_bytes.pop_front();
				if (m_tdata[7:0] !== next_byte.body_byte || m_tlast !== next_byte.run_end ||
						m_tdata[39:8] !== next_byte.length) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: expected byte %02h last %0b length %0d, got %02h %0b %0d",
							next_byte.body_byte, next_byte.run_end, next_byte.length,
							m_tdata[7:0], m_tlast, m_tdata[39:8]);
				end
			end
		end
	end

	// receiver stalls in random bursts when rx_idle_en is set
	always @(posedge clk) begin
		if (rx_gap != 0) begin
			rx_gap <= rx_gap - 1;
			m_tready <= 1'b0;
		end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
			rx_gap <= $urandom_range(0, 3);
			m_tready <= 1'b0;
		end else
			m_tready <= 1'b1;
	end

	// ---------------------------------------------------------------- driving

	// entered and left just after a rising edge
	task automatic send_item(input logic [1:0] op, input logic [47:0] frame,
			input logic [7:0] payload);
		if (tx_idle_en && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {payload, frame};
		s_tuser <= op;
		do @(posedge clk); while (!s_tready);
		predict_track_bytes(op, frame, payload);
	endtask

	task automatic send_step(input longint step);
		send_item(OP_TIME, prev_frame + 48'(step), 8'($urandom));
	endtask

	// hold the sender until every byte is out, then let the block settle
	task automatic drain_track;
		s_tvalid <= 1'b0;
		while (pending_bytes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic set_factor(input logic [31:0] value);
		drain_track();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		tps_q = value;
	endtask

	// ---------------------------------------------------------------- tests

	task automatic test_payload_and_end;
		send_item(OP_PAYLOAD, 48'h0, 8'h00);
		send_item(OP_PAYLOAD, 48'hFFFF_FFFF_FFFF, 8'hFF);
		send_item(OP_PAYLOAD, 48'h5555_5555_5555, 8'hA5);
		send_item(OP_END, 48'hAAAA_AAAA_AAAA, 8'h5A);
		send_item(OP_UNUSED, 48'hFFFF_FFFF_FFFF, 8'hFF);
		send_item(OP_PAYLOAD, 48'h0, 8'h5A);
	endtask

	// unit factor: the delta equals the distance, so each length boundary is hit exactly
	task automatic test_delta_boundaries;
		set_factor(TPS_ONE);
		send_step(0);
		send_step(127);
		send_step(128);
		send_step(16383);
		send_step(16384);
		send_step(2097151);
		send_step(2097152);
		send_step(64'h0FFF_FFFF);
		send_step(64'h1000_0000);
		send_item(OP_TIME, 48'd0, 8'h00);             // negative distance
		send_item(OP_TIME, 48'hFFFF_FFFF_FFFF, 8'h00); // huge forward jump
		send_item(OP_TIME, 48'd0, 8'h00);             // huge backward jump
	endtask

	// half a tick per frame: halves round up and the residual carries over
	task automatic test_rounding_halves;
		set_factor(TPS_HALF);
		send_step(1);
		send_step(1);
		send_step(1);
		send_step(-1);
	endtask

	task automatic test_factor_extremes;
		set_factor(32'd0);
		send_step(5);
		set_factor(32'hFFFF_FFFF);
		send_step(2097151);
		send_step(2097152);
	endtask

	// events of a timestamp and a few content bytes, with some noise mixed in
	task automatic test_random_track(input int nitems, input logic [31:0] factor,
			input bit tx_idle, input bit rx_idle);
		int sent;
		int kind;
		sent = 0;
		set_factor(factor);
		tx_idle_en = tx_idle;
		rx_idle_en = rx_idle;
		while (sent < nitems) begin
			kind = $urandom_range(0, 19);
			if (kind < 15) begin
				case ($urandom_range(0, 9))
					0: send_step($urandom_range(0, 3));
					1, 2, 3: send_step($urandom_range(0, 255));
					4, 5: send_step($urandom_range(0, 65535));
					6: send_step($urandom_range(0, 1 << 22));
					7: send_step($urandom & 32'h3FFF_FFFF);
					8: send_step(-longint'($urandom_range(0, 1000)));
					default: send_item(OP_TIME, 48'({$urandom, $urandom}), 8'($urandom));
				endcase
				sent++;
				repeat ($urandom_range(1, 3)) begin
					send_item(OP_PAYLOAD, 48'({$urandom, $urandom}), 8'($urandom));
					sent++;
				end
			end else if (kind < 17) begin
				send_item(OP_END, 48'({$urandom, $urandom}), 8'($urandom));
				sent++;
			end else if (kind < 19) begin
				send_item(OP_PAYLOAD, 48'({$urandom, $urandom}), 8'($urandom));
				sent++;
			end else
				send_item(OP_UNUSED, 48'({$urandom, $urandom}), 8'($urandom));
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_payload_and_end();
		test_delta_boundaries();
		test_rounding_halves();
		test_factor_extremes();
		test_random_track(50, TPS_RESET, 1'b1, 1'b1);
		test_random_track(50, $urandom, 1'b1, 1'b0);
		test_random_track(50, TPS_ONE, 1'b0, 1'b1);
		test_random_track(50, 32'hFFFF_FFFF, 1'b1, 1'b1);
		test_random_track(40, $urandom_range(0, 32'h0400_0000), 1'b1, 1'b1);
		test_random_track(20, 32'd0, 1'b1, 1'b1);
		// closing stretch with both sides flat out
		test_random_track(50, $urandom, 1'b0, 1'b0);
		drain_track();
		if (mismatch_count == 0 && pending_bytes.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

>>> filelist.f
rtl/mtde_pkg.sv
rtl/mtde_ctrl.sv
rtl/mtde_dp.sv
rtl/midi_track_delta_time_encoder_top.sv
sim/testbench.sv
